### src/apsp_pkg.sv
// Shared types, constants and arithmetic for the all-pairs shortest path block.
package apsp_pkg;

    // Default matrix size in nodes.
    localparam int DEF_MAX_NODES = 8;

    // Field widths fixed by the interface.
    localparam int DIST_W    = 48;
    localparam int ENTRY_W   = DIST_W + 1;
    localparam int NODE_W    = 3;
    localparam int WEIGHT_W  = 32;
    localparam int COUNT_W   = 4;

    // Node count after reset.
    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 4'd8;

    // Saturation limits of a stored distance.
    localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // Operation codes carried by an input word.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    // Adds two signed distances and clamps the result to the 48-bit limits.
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
        if (s[DIST_W] != s[DIST_W-1]) begin
            return s[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        return s[DIST_W-1:0];
    endfunction

endpackage

### src/apsp_ram.sv
// Generic RAM with one write port and two registered read ports.
module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### src/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest path block (Floyd-Warshall relaxation).
//
//  Channel   Direction  Handshake            Contents
//  input     in         i_valid / o_stall    i_opcode, i_src_node, i_dst_node, i_edge_weight
//  output    out        o_valid / i_stall    o_distance, o_unreachable, o_negative_cycle,
//                                            o_cycle_node
//  config    in         i_cfg_we             i_cfg_wdata (node count)
//
// Load and read handle one entry each; clear sweeps the whole matrix RAM,
// one entry a cycle through its write port. For the n nodes in use, run
// relaxes every (k,i,j) triple and then scans the diagonal; each relaxation step
// reads two legs, then the target entry, then writes it back on the same RAM.
// After reset the same clearing sweep runs before the first word is accepted.
// Only one word is in work at a time; a result waiting on i_stall holds o_stall.
module all_pairs_shortest_path
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [COUNT_W-1:0]         i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_opcode,
    input  logic [NODE_W-1:0]          i_src_node,
    input  logic [NODE_W-1:0]          i_dst_node,
    input  logic signed [WEIGHT_W-1:0] i_edge_weight,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [DIST_W-1:0]   o_distance,
    output logic                       o_unreachable,
    output logic                       o_negative_cycle,
    output logic [NODE_W-1:0]          o_cycle_node
);

    localparam int IW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_REL_A,
        S_REL_B,
        S_REL_C,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_sweep, n_sweep;
    logic                 r_clr_reply, n_clr_reply;
    logic [COUNT_W-1:0]   r_node_count, n_node_count;
    logic [CW-1:0]        r_n, n_n;
    logic [IW-1:0]        r_k, n_k;
    logic [IW-1:0]        r_i, n_i;
    logic [IW-1:0]        r_j, n_j;
    logic [DIST_W-1:0]    r_sum, n_sum;
    logic                 r_skip, n_skip;
    logic                 r_rd_bad, n_rd_bad;
    logic                 r_neg_found, n_neg_found;
    logic [IW-1:0]        r_neg_node, n_neg_node;
    logic                 r_out_vld, n_out_vld;
    logic [DIST_W-1:0]    r_out_dist, n_out_dist;
    logic                 r_out_unr, n_out_unr;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr_a;
    logic [AW-1:0]        ram_raddr_b;
    logic [ENTRY_W-1:0]   ram_rdata_a;
    logic [ENTRY_W-1:0]   ram_rdata_b;

    logic                 in_acc;
    logic                 in_range;
    logic [IW-1:0]        in_src;
    logic [IW-1:0]        in_dst;
    logic [CW-1:0]        n_eff;
    logic [CW-1:0]        n_last;
    logic                 last_k, last_i, last_j;

    // Matrix storage: bit 48 marks an infinite entry, the rest is the distance.
    apsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    // Input handshake: one word at a time, only when the result register is free or being taken.
    assign o_stall = !((r_state == S_IDLE) && (!r_out_vld || !i_stall));
    assign in_acc  = i_valid && !o_stall;

    assign in_src   = IW'(i_src_node);
    assign in_dst   = IW'(i_dst_node);
    assign in_range = (32'(i_src_node) < MAX_NODES) && (32'(i_dst_node) < MAX_NODES);

    // Node count in use, clamped to the matrix size.
    assign n_eff  = (32'(r_node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(r_node_count);
    assign n_last = r_n - CW'(1);
    assign last_k = (CW'(r_k) == n_last);
    assign last_i = (CW'(r_i) == n_last);
    assign last_j = (CW'(r_j) == n_last);

    // Next-state logic, RAM control and result formation.
    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_clr_reply  = r_clr_reply;
        n_node_count = i_cfg_we ? i_cfg_wdata : r_node_count;
        n_n          = r_n;
        n_k          = r_k;
        n_i          = r_i;
        n_j          = r_j;
        n_sum        = r_sum;
        n_skip       = r_skip;
        n_rd_bad     = r_rd_bad;
        n_neg_found  = r_neg_found;
        n_neg_node   = r_neg_node;
        n_out_vld    = r_out_vld && i_stall;
        n_out_dist   = r_out_dist;
        n_out_unr    = r_out_unr;

        ram_we      = 1'b0;
        ram_waddr   = {r_i, r_j};
        ram_wdata   = '0;
        ram_raddr_a = {r_i, r_k};
        ram_raddr_b = {r_k, r_j};

        unique case (r_state)
            // Clearing sweep: infinite everywhere except a zero diagonal.
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = (r_sweep[AW-1:IW] == r_sweep[IW-1:0]) ? '0
                                                                  : {1'b1, {DIST_W{1'b0}}};
                n_sweep   = r_sweep + AW'(1);
                if (r_sweep == {AW{1'b1}}) begin
                    n_state = S_IDLE;
                    if (r_clr_reply) begin
                        n_clr_reply = 1'b0;
                        n_out_vld   = 1'b1;
                        n_out_dist  = '0;
                        n_out_unr   = 1'b0;
                    end
                end
            end

            // Wait for a word and dispatch on its opcode.
            S_IDLE: begin
                ram_raddr_a = {in_src, in_dst};
                if (in_acc) begin
                    unique case (t_opcode'(i_opcode))
                        OP_CLEAR: begin
                            n_sweep     = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_INIT;
                        end
                        OP_LOAD: begin
                            ram_we     = in_range;
                            ram_waddr  = {in_src, in_dst};
                            ram_wdata  = {1'b0, {(DIST_W-WEIGHT_W){i_edge_weight[WEIGHT_W-1]}},
                                          i_edge_weight};
                            n_out_vld  = 1'b1;
                            n_out_dist = '0;
                            n_out_unr  = 1'b0;
                        end
                        OP_RUN: begin
                            n_n         = n_eff;
                            n_k         = '0;
                            n_i         = '0;
                            n_j         = '0;
                            n_neg_found = 1'b0;
                            n_neg_node  = '0;
                            n_state     = (n_eff == '0) ? S_DONE : S_REL_A;
                        end
                        OP_READ: begin
                            n_rd_bad = !in_range;
                            n_state  = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Read data is back: form the result.
            S_READ: begin
                n_out_vld = 1'b1;
                if (r_rd_bad || ram_rdata_a[DIST_W]) begin
                    n_out_dist = '0;
                    n_out_unr  = 1'b1;
                end else begin
                    n_out_dist = ram_rdata_a[DIST_W-1:0];
                    n_out_unr  = 1'b0;
                end
                n_state = S_IDLE;
            end

            // Relaxation step, first state: fetch the legs (i,k) and (k,j).
            S_REL_A: begin
                n_state = S_REL_B;
            end

            // Legs are back: form the saturated path sum and fetch (i,j).
            S_REL_B: begin
                ram_raddr_a = {r_i, r_j};
                n_skip      = ram_rdata_a[DIST_W] || ram_rdata_b[DIST_W];
                n_sum       = sat_add(ram_rdata_a[DIST_W-1:0], ram_rdata_b[DIST_W-1:0]);
                n_state     = S_REL_C;
            end

            // Compare with the current entry, write back if shorter, step j, i, k.
            S_REL_C: begin
                if (!r_skip && (ram_rdata_a[DIST_W] ||
                        ($signed(r_sum) < $signed(ram_rdata_a[DIST_W-1:0])))) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_i, r_j};
                    ram_wdata = {1'b0, r_sum};
                end
                n_state = S_REL_A;
                if (!last_j) begin
                    n_j = r_j + IW'(1);
                end else begin
                    n_j = '0;
                    if (!last_i) begin
                        n_i = r_i + IW'(1);
                    end else begin
                        n_i = '0;
                        if (!last_k) begin
                            n_k = r_k + IW'(1);
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                end
            end

            // Diagonal scan: fetch entry (i,i).
            S_SCAN_RD: begin
                ram_raddr_a = {r_i, r_i};
                n_state     = S_SCAN_CHK;
            end

            // A finite negative diagonal marks the highest such node so far.
            S_SCAN_CHK: begin
                if (!ram_rdata_a[DIST_W] && ram_rdata_a[DIST_W-1]) begin
                    n_neg_found = 1'b1;
                    n_neg_node  = r_i;
                end
                if (last_i) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_SCAN_RD;
                end
            end

            // Run finished: report it.
            S_DONE: begin
                n_out_vld  = 1'b1;
                n_out_dist = '0;
                n_out_unr  = 1'b0;
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_sweep      <= '0;
            r_clr_reply  <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
            r_neg_found  <= 1'b0;
            r_neg_node   <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_clr_reply  <= n_clr_reply;
            r_node_count <= n_node_count;
            r_neg_found  <= n_neg_found;
            r_neg_node   <= n_neg_node;
            r_out_vld    <= n_out_vld;
        end
        r_n        <= n_n;
        r_k        <= n_k;
        r_i        <= n_i;
        r_j        <= n_j;
        r_sum      <= n_sum;
        r_skip     <= n_skip;
        r_rd_bad   <= n_rd_bad;
        r_out_dist <= n_out_dist;
        r_out_unr  <= n_out_unr;
    end

    assign o_valid          = r_out_vld;
    assign o_distance       = r_out_dist;
    assign o_unreachable    = r_out_unr;
    assign o_negative_cycle = r_neg_found;
    assign o_cycle_node     = NODE_W'(r_neg_node);

endmodule
